FILE: design/lcdws_pkg.sv
// Shared types, constants and helper functions of the character LCD write sequencer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lcdws_pkg;

  // Request kinds on the input tuser field.
  localparam logic [1:0] REQ_INSTR  = 2'd0;
  localparam logic [1:0] REQ_CHAR   = 2'd1;
  localparam logic [1:0] REQ_CURSOR = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BUS_WIDTH_MODE = 2'd0;
  localparam logic [1:0] CFG_NIBBLE_LANE    = 2'd1;
  localparam logic [1:0] CFG_HOLD_TICKS     = 2'd2;

  localparam logic        BUS_WIDTH_MODE_RESET = 1'b0;
  localparam logic        NIBBLE_LANE_RESET    = 1'b1;
  localparam logic [15:0] HOLD_TICKS_RESET     = 16'd1000;

  // DDRAM address command and the row start offsets.
  localparam logic [7:0] SET_DDRAM_ADDR = 8'h80;
  localparam logic [7:0] ROW0_OFFSET    = 8'h00;
  localparam logic [7:0] ROW1_OFFSET    = 8'h40;
  localparam logic [7:0] ROW2_OFFSET    = 8'h10;
  localparam logic [7:0] ROW3_OFFSET    = 8'h50;
  localparam logic [7:0] HIGH_NIBBLE    = 8'hF0;
  localparam logic [7:0] LOW_NIBBLE     = 8'h0F;

  // Pin phases of one write.
  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_SETUP   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_E_RISE  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_HI_DATA = 3'd2;
  localparam logic [PHASE_W-1:0] PH_HI_FALL = 3'd3;
  localparam logic [PHASE_W-1:0] PH_LO_RISE = 3'd4;
  localparam logic [PHASE_W-1:0] PH_LO_DATA = 3'd5;
  localparam logic [PHASE_W-1:0] PH_LO_FALL = 3'd6;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic        rs;
    logic [7:0]  val;
  } lcdws_req_t;

  typedef struct packed {
    logic        bus_width_mode;
    logic        nibble_lane;
    logic [15:0] hold_ticks;
  } lcdws_cfg_t;

  function automatic logic [7:0] row_offset(input logic [1:0] row);
    logic [7:0] off;
    case (row)
      2'd0:    off = ROW0_OFFSET;
      2'd1:    off = ROW1_OFFSET;
      2'd2:    off = ROW2_OFFSET;
      default: off = ROW3_OFFSET;
    endcase
    return off;
  endfunction

  // Places a nibble on the chosen lane and keeps the other lane of the latch.
  function automatic logic [7:0] lane_merge(input logic [7:0] latch, input logic lane,
                                            input logic [3:0] nib);
    logic [7:0] res;
    if (lane) begin
      res = (latch & LOW_NIBBLE) | {nib, 4'h0};
    end else begin
      res = (latch & HIGH_NIBBLE) | {4'h0, nib};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/lcdws_front.sv
// Front end: classifies a write request and forms the byte and RS level to send.
// Depends on lcdws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcdws_front (
  input  wire logic [1:0]         req_type,
  input  wire logic [7:0]         byte_value,
  input  wire logic [1:0]         row_index,
  input  wire logic [5:0]         column_index,
  output lcdws_pkg::lcdws_req_t   req,
  output logic                    req_known
);

  logic [7:0] addr;

  assign addr = {2'b00, column_index} + lcdws_pkg::row_offset(row_index);

  always_comb begin
    req_known = 1'b1;
    req.rs    = 1'b0;
    req.val   = byte_value;
    case (req_type)
      lcdws_pkg::REQ_INSTR: begin
        req.rs = 1'b0;
      end
      lcdws_pkg::REQ_CHAR: begin
        req.rs = 1'b1;
      end
      lcdws_pkg::REQ_CURSOR: begin
        req.val = addr | lcdws_pkg::SET_DDRAM_ADDR;
      end
      default: begin
        // Unknown kinds are consumed and dropped.
        req_known = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/lcdws_queue.sv
// Short FIFO of classified requests between the front and back ends.
// Depends on lcdws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcdws_queue #(
  parameter int DEPTH = lcdws_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire lcdws_pkg::lcdws_req_t push_item,
  output logic                       full,
  input  wire logic                  pop,
  output lcdws_pkg::lcdws_req_t      head,
  output logic                       not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lcdws_pkg::lcdws_req_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: design/lcdws_back.sv
// Back end: steps through the pin phases of one write, paces them by the hold
// time and keeps the bus latch. Depends on lcdws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcdws_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lcdws_pkg::lcdws_cfg_t cfg,
  input  wire lcdws_pkg::lcdws_req_t q_head,
  input  wire logic                  q_not_empty,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_rs,
  output logic                       out_en,
  output logic [7:0]                 out_bus,
  output logic                       out_last
);

  localparam int PW = lcdws_pkg::PHASE_W;

  logic                  active_r, active_nxt;
  logic [PW-1:0]         phase_r, phase_nxt;
  lcdws_pkg::lcdws_req_t cur_r, cur_nxt;
  logic [7:0]            latch_r, latch_nxt;
  logic [15:0]           wait_r, wait_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  rs_r, en_r, last_r;
  logic [7:0]            bus_r;

  logic                  issue;
  logic [PW-1:0]         ph;
  lcdws_pkg::lcdws_req_t itm;
  logic [PW-1:0]         last_ph;
  logic                  ph_en;

  always_comb begin
    ph      = active_r ? phase_r : lcdws_pkg::PH_SETUP;
    itm     = active_r ? cur_r : q_head;
    last_ph = cfg.bus_width_mode ? lcdws_pkg::PH_HI_FALL : lcdws_pkg::PH_LO_FALL;
    issue   = (wait_r == '0) && (!out_valid_r || out_ready) && (active_r || q_not_empty);
    q_pop   = issue && !active_r;
    ph_en   = (ph == lcdws_pkg::PH_E_RISE) || (ph == lcdws_pkg::PH_HI_DATA) ||
              (ph == lcdws_pkg::PH_LO_RISE) || (ph == lcdws_pkg::PH_LO_DATA);

    latch_nxt = latch_r;
    if (ph == lcdws_pkg::PH_HI_DATA) begin
      latch_nxt = cfg.bus_width_mode ? itm.val
                : lcdws_pkg::lane_merge(latch_r, cfg.nibble_lane, itm.val[7:4]);
    end else if (ph == lcdws_pkg::PH_LO_DATA && !cfg.bus_width_mode) begin
      latch_nxt = lcdws_pkg::lane_merge(latch_r, cfg.nibble_lane, itm.val[3:0]);
    end

    active_nxt    = active_r;
    phase_nxt     = phase_r;
    cur_nxt       = cur_r;
    wait_nxt      = (wait_r != '0) ? wait_r - 1'b1 : wait_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (issue) begin
      out_valid_nxt = 1'b1;
      cur_nxt       = itm;
      wait_nxt      = (cfg.hold_ticks != '0) ? cfg.hold_ticks - 1'b1 : '0;
      if (ph == last_ph) begin
        active_nxt = 1'b0;
        phase_nxt  = lcdws_pkg::PH_SETUP;
      end else begin
        active_nxt = 1'b1;
        phase_nxt  = ph + 1'b1;
      end
    end else begin
      latch_nxt = latch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      phase_r     <= lcdws_pkg::PH_SETUP;
      latch_r     <= '0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      phase_r     <= phase_nxt;
      latch_r     <= latch_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (issue) begin
      rs_r   <= itm.rs;
      en_r   <= ph_en;
      bus_r  <= latch_nxt;
      last_r <= (ph == last_ph);
    end
  end

  assign out_valid = out_valid_r;
  assign out_rs    = rs_r;
  assign out_en    = en_r;
  assign out_bus   = bus_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

FILE: design/char_lcd_write_sequencer_unit.sv
// Top level of the character LCD write sequencer: configuration registers,
// front end, request FIFO and phase sequencer. Depends on lcdws_pkg.
//
// Usage: a write request enters on the in_ stream (kind in in_tuser; byte,
// row and column in in_tdata). Each request becomes a run of display pin
// states on the out_ stream, one beat per state, with out_tlast on the last.
// 8-bit mode gives four beats per write, 4-bit mode seven. A request of the
// unknown kind is taken and gives no beats.
// Timing: the first beat of a write is presented once the request has passed
// through the request FIFO and the output register of the sequencer, when the
// sequencer is free. Consecutive beats are paced by the hold counter in the
// sequencer, which is loaded from hold_ticks at each beat.
// The request FIFO takes new requests while the sequencer is busy; in_tready
// drops only when it is full. A stalled receiver holds the current beat while
// the hold counter keeps running, so nothing is lost and the next beat goes
// out as soon as the held one is taken and the hold time has passed.
// Reset (rst_n low at a clock edge) empties the FIFO, clears the bus latch and
// loads 4-bit mode, upper nibble lane and hold_ticks 1000. The user, not the
// block, keeps configuration writes via cfg_we/cfg_index/cfg_data to idle.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_write_sequencer_unit #(
  parameter int QUEUE_DEPTH = lcdws_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] byte_value, [9:8] row_index, [15:10] column_index
  input  wire logic [15:0] in_tdata,
  // [1:0] req_type
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] reg_select, [1] read_write, [2] enable_pin, [10:3] data_bus, [15:11] zero
  output logic [15:0]      out_tdata,
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  lcdws_pkg::lcdws_cfg_t cfg_r;
  lcdws_pkg::lcdws_req_t front_req;
  lcdws_pkg::lcdws_req_t q_head;
  logic                  req_known;
  logic                  q_full;
  logic                  q_not_empty;
  logic                  q_pop;
  logic                  in_fire;
  logic                  out_rs;
  logic                  out_en;
  logic [7:0]            out_bus;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bus_width_mode <= lcdws_pkg::BUS_WIDTH_MODE_RESET;
      cfg_r.nibble_lane    <= lcdws_pkg::NIBBLE_LANE_RESET;
      cfg_r.hold_ticks     <= lcdws_pkg::HOLD_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lcdws_pkg::CFG_BUS_WIDTH_MODE: cfg_r.bus_width_mode <= cfg_data[0];
        lcdws_pkg::CFG_NIBBLE_LANE:    cfg_r.nibble_lane    <= cfg_data[0];
        lcdws_pkg::CFG_HOLD_TICKS:     cfg_r.hold_ticks     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lcdws_front u_front (
    .req_type     (in_tuser),
    .byte_value   (in_tdata[7:0]),
    .row_index    (in_tdata[9:8]),
    .column_index (in_tdata[15:10]),
    .req          (front_req),
    .req_known    (req_known)
  );

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  lcdws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire && req_known),
    .push_item (front_req),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty)
  );

  lcdws_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_head      (q_head),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_rs      (out_rs),
    .out_en      (out_en),
    .out_bus     (out_bus),
    .out_last    (out_tlast)
  );

  // RW is always low: the block only writes.
  assign out_tdata = {5'b00000, out_bus, out_en, 1'b0, out_rs};

endmodule

`default_nettype wire
